// File: hdl/fqe_pkg.sv
// ----------------------------------------------------------------------------
// Framed quadrature encoder emulator package
// Shared types, constants and helper functions for the emulator block.
// ----------------------------------------------------------------------------
package fqe_pkg;

    localparam int CHANNELS_DEF    = 2;
    localparam int MAX_PAYLOAD_DEF = 256;
    localparam int QUEUE_DEPTH     = 2;

    localparam int CFG_IDX_W = 8;
    localparam logic [CFG_IDX_W-1:0] CFG_SYNC_FIRST  = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SYNC_SECOND = 8'd1;

    localparam logic [7:0] SYNC_FIRST_RST  = 8'hAA;
    localparam logic [7:0] SYNC_SECOND_RST = 8'h55;
    localparam logic [7:0] TYPE_BYTE       = 8'h40;

    localparam int LEN_BYTES  = 4;
    localparam int RECORD_LEN = 5;
    localparam int HEADER_LEN = 2;

    localparam logic KIND_BYTE = 1'b0;
    localparam logic KIND_TICK = 1'b1;

    localparam logic [1:0] GRAY_0 = 2'b00;
    localparam logic [1:0] GRAY_1 = 2'b01;
    localparam logic [1:0] GRAY_2 = 2'b11;
    localparam logic [1:0] GRAY_3 = 2'b10;

    typedef enum logic [2:0] {
        RX_SYNC0,
        RX_SYNC1,
        RX_LEN,
        RX_PAY,
        RX_SUM
    } t_rx_phase;

    typedef struct packed {
        logic       kind;
        logic [7:0] data_byte;
    } t_in_item;

    typedef struct packed {
        logic [3:0]  quad_lines;
        logic        frame_done;
        logic [31:0] frames_total;
    } t_out_item;

    typedef struct packed {
        logic [CFG_IDX_W-1:0] index;
        logic [7:0]           data;
    } t_cfg_wr;

    // Classified item handed from the front end to the execution engine.
    typedef struct packed {
        logic       is_tick;
        logic [7:0] data;
        logic       hit_first;
        logic       hit_second;
        logic       is_type;
    } t_op;

    function automatic logic [1:0] f_gray(input logic [1:0] phase);
        logic [1:0] levels;
        case (phase)
            2'd0: levels = GRAY_0;
            2'd1: levels = GRAY_1;
            2'd2: levels = GRAY_2;
            2'd3: levels = GRAY_3;
            default: levels = GRAY_0;
        endcase
        return levels;
    endfunction

endpackage

// File: hdl/fqe_fifo.sv
// ----------------------------------------------------------------------------
// Register FIFO
// Small first-in first-out queue built from flip-flops.
// ----------------------------------------------------------------------------
module fqe_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = fqe_pkg::QUEUE_DEPTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wr_ptr, n_wr_ptr;
    logic [AW-1:0]    r_rd_ptr, n_rd_ptr;
    logic [CW-1:0]    r_count, n_count;
    logic             w_do_push;
    logic             w_do_pop;

    assign o_full    = (r_count == CW'(DEPTH));
    assign o_empty   = (r_count == '0);
    assign o_data    = r_mem[r_rd_ptr];
    assign w_do_push = i_push && !o_full;
    assign w_do_pop  = i_pop && !o_empty;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (w_do_push) begin
            n_wr_ptr = (r_wr_ptr == AW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (w_do_pop) begin
            n_rd_ptr = (r_rd_ptr == AW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        case ({w_do_push, w_do_pop})
            2'b10:   n_count = r_count + 1'b1;
            2'b01:   n_count = r_count - 1'b1;
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("FIFO occupancy exceeds its depth.");

endmodule

// File: hdl/fqe_front.sv
// ----------------------------------------------------------------------------
// Emulator front end
// Holds the sync configuration and classifies each incoming transaction.
// ----------------------------------------------------------------------------
module fqe_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  fqe_pkg::t_cfg_wr   i_cfg,
    input  fqe_pkg::t_in_item  i_item,
    output fqe_pkg::t_op       o_op
);

    logic [7:0] r_sync_first, n_sync_first;
    logic [7:0] r_sync_second, n_sync_second;

    assign o_cfg_ready = 1'b1;

    always_comb begin
        n_sync_first  = r_sync_first;
        n_sync_second = r_sync_second;
        if (i_cfg_valid) begin
            case (i_cfg.index)
                fqe_pkg::CFG_SYNC_FIRST:  n_sync_first  = i_cfg.data;
                fqe_pkg::CFG_SYNC_SECOND: n_sync_second = i_cfg.data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sync_first  <= fqe_pkg::SYNC_FIRST_RST;
            r_sync_second <= fqe_pkg::SYNC_SECOND_RST;
        end else begin
            r_sync_first  <= n_sync_first;
            r_sync_second <= n_sync_second;
        end
    end

    always_comb begin
        o_op.is_tick    = (i_item.kind == fqe_pkg::KIND_TICK);
        o_op.data       = i_item.data_byte;
        o_op.hit_first  = (i_item.data_byte == r_sync_first);
        o_op.hit_second = (i_item.data_byte == r_sync_second);
        o_op.is_type    = (i_item.data_byte == fqe_pkg::TYPE_BYTE);
    end

endmodule

// File: hdl/fqe_back.sv
// ----------------------------------------------------------------------------
// Emulator execution engine
// Parses frames byte by byte, commits targets and steps the channels.
// ----------------------------------------------------------------------------
module fqe_back #(
    parameter int CHANNELS    = fqe_pkg::CHANNELS_DEF,
    parameter int MAX_PAYLOAD = fqe_pkg::MAX_PAYLOAD_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  fqe_pkg::t_op       i_op,
    input  logic               i_op_valid,
    output logic               o_op_pop,
    input  logic               i_res_full,
    output logic               o_res_push,
    output fqe_pkg::t_out_item o_result
);

    localparam int PL_W   = $clog2(MAX_PAYLOAD + 1);
    localparam int CH_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int CMP_W  = PL_W + 12;
    localparam int VIS_CH = (CHANNELS < 2) ? CHANNELS : 2;

    fqe_pkg::t_rx_phase r_rx_phase, n_rx_phase;
    logic [31:0]     r_length_shift, n_length_shift;
    logic [1:0]      r_length_index, n_length_index;
    logic [PL_W-1:0] r_payload_len, n_payload_len;
    logic [PL_W-1:0] r_payload_index, n_payload_index;
    logic [PL_W-1:0] r_record_num, n_record_num;
    logic [7:0]      r_xor_sum, n_xor_sum;
    logic            r_type_ok, n_type_ok;
    logic [7:0]      r_record_count, n_record_count;
    logic [2:0]      r_record_byte_index, n_record_byte_index;
    logic [7:0]      r_record_channel, n_record_channel;
    logic [31:0]     r_record_value, n_record_value;
    logic [31:0]     r_pending_target [CHANNELS];
    logic [31:0]     n_pending_target [CHANNELS];
    logic [CHANNELS-1:0] r_pending_set, n_pending_set;
    logic [31:0]     r_target_pos [CHANNELS];
    logic [31:0]     n_target_pos [CHANNELS];
    logic [31:0]     r_current_pos [CHANNELS];
    logic [31:0]     n_current_pos [CHANNELS];
    logic [1:0]      r_quad_phase [CHANNELS];
    logic [1:0]      n_quad_phase [CHANNELS];
    logic [31:0]     r_frame_counter, n_frame_counter;

    logic             w_fire;
    logic             w_restart;
    logic             w_done;
    logic             w_len_ok;
    logic             w_rec_ok;
    logic [CMP_W-1:0] w_need_len;
    logic [3:0]       w_lines;

    assign w_fire     = i_op_valid && !i_res_full;
    assign o_op_pop   = w_fire;
    assign o_res_push = w_fire;

    assign w_need_len = CMP_W'(fqe_pkg::HEADER_LEN)
                      + (CMP_W'(r_record_count) << 2) + CMP_W'(r_record_count);
    assign w_len_ok   = (CMP_W'(r_payload_len) >= CMP_W'(fqe_pkg::HEADER_LEN))
                     && (CMP_W'(r_payload_len) >= w_need_len);
    assign w_rec_ok   = r_type_ok
                     && (CMP_W'(r_record_num) < CMP_W'(r_record_count))
                     && ({1'b0, r_record_channel} < 9'(CHANNELS));

    always_comb begin
        n_rx_phase          = r_rx_phase;
        n_length_shift      = r_length_shift;
        n_length_index      = r_length_index;
        n_payload_len       = r_payload_len;
        n_payload_index     = r_payload_index;
        n_record_num        = r_record_num;
        n_xor_sum           = r_xor_sum;
        n_type_ok           = r_type_ok;
        n_record_count      = r_record_count;
        n_record_byte_index = r_record_byte_index;
        n_record_channel    = r_record_channel;
        n_record_value      = r_record_value;
        n_pending_target    = r_pending_target;
        n_pending_set       = r_pending_set;
        n_target_pos        = r_target_pos;
        n_current_pos       = r_current_pos;
        n_quad_phase        = r_quad_phase;
        n_frame_counter     = r_frame_counter;
        w_restart           = 1'b0;
        w_done              = 1'b0;

        if (w_fire && i_op.is_tick) begin
            for (int c = 0; c < CHANNELS; c++) begin
                if ($signed(r_target_pos[c]) > $signed(r_current_pos[c])) begin
                    n_quad_phase[c]  = r_quad_phase[c] + 2'd1;
                    n_current_pos[c] = r_current_pos[c] + 32'd1;
                end else if ($signed(r_target_pos[c]) < $signed(r_current_pos[c])) begin
                    n_quad_phase[c]  = r_quad_phase[c] - 2'd1;
                    n_current_pos[c] = r_current_pos[c] - 32'd1;
                end
            end
        end else if (w_fire) begin
            case (r_rx_phase)
                fqe_pkg::RX_SYNC0: begin
                    if (i_op.hit_first) begin
                        n_rx_phase = fqe_pkg::RX_SYNC1;
                    end
                end
                fqe_pkg::RX_SYNC1: begin
                    if (i_op.hit_second) begin
                        n_rx_phase     = fqe_pkg::RX_LEN;
                        n_length_index = '0;
                        n_length_shift = '0;
                    end else if (!i_op.hit_first) begin
                        w_restart = 1'b1;
                    end
                end
                fqe_pkg::RX_LEN: begin
                    n_length_shift = r_length_shift
                                   | (32'(i_op.data) << {r_length_index, 3'b000});
                    if (r_length_index == 2'(fqe_pkg::LEN_BYTES - 1)) begin
                        n_length_index = '0;
                        if ((n_length_shift == '0)
                                || (n_length_shift > 32'(MAX_PAYLOAD))) begin
                            w_restart = 1'b1;
                        end else begin
                            n_payload_len       = n_length_shift[PL_W-1:0];
                            n_payload_index     = '0;
                            n_record_num        = '0;
                            n_xor_sum           = '0;
                            n_type_ok           = 1'b0;
                            n_record_count      = '0;
                            n_record_byte_index = '0;
                            n_record_channel    = '0;
                            n_record_value      = '0;
                            n_pending_set       = '0;
                            n_rx_phase          = fqe_pkg::RX_PAY;
                        end
                    end else begin
                        n_length_index = r_length_index + 2'd1;
                    end
                end
                fqe_pkg::RX_PAY: begin
                    if (r_payload_index == PL_W'(0)) begin
                        n_type_ok = i_op.is_type;
                    end else if (r_payload_index == PL_W'(1)) begin
                        n_record_count      = i_op.data;
                        n_record_byte_index = '0;
                    end else begin
                        if (r_record_byte_index == '0) begin
                            n_record_channel = i_op.data;
                            n_record_value   = '0;
                        end else begin
                            n_record_value = r_record_value | (32'(i_op.data)
                                << {r_record_byte_index[1:0] - 2'd1, 3'b000});
                        end
                        if (r_record_byte_index >= 3'(fqe_pkg::RECORD_LEN - 1)) begin
                            n_record_byte_index = '0;
                            n_record_num        = r_record_num + 1'b1;
                            if (w_rec_ok) begin
                                n_pending_target[r_record_channel[CH_W-1:0]] =
                                    n_record_value;
                                n_pending_set[r_record_channel[CH_W-1:0]] = 1'b1;
                            end
                        end else begin
                            n_record_byte_index = r_record_byte_index + 3'd1;
                        end
                    end
                    n_xor_sum       = r_xor_sum ^ i_op.data;
                    n_payload_index = r_payload_index + 1'b1;
                    if (n_payload_index >= r_payload_len) begin
                        n_rx_phase = fqe_pkg::RX_SUM;
                    end
                end
                fqe_pkg::RX_SUM: begin
                    if (i_op.data == r_xor_sum) begin
                        if (r_type_ok && w_len_ok) begin
                            for (int c = 0; c < CHANNELS; c++) begin
                                if (r_pending_set[c]) begin
                                    n_target_pos[c] = r_pending_target[c];
                                end
                            end
                        end
                        n_pending_set   = '0;
                        n_rx_phase      = fqe_pkg::RX_SYNC0;
                        w_done          = 1'b1;
                        n_frame_counter = r_frame_counter + 32'd1;
                    end else begin
                        w_restart = 1'b1;
                    end
                end
                default: begin
                    w_restart = 1'b1;
                end
            endcase
        end

        if (w_restart) begin
            n_rx_phase      = fqe_pkg::RX_SYNC0;
            n_length_index  = '0;
            n_payload_len   = '0;
            n_payload_index = '0;
            n_xor_sum       = '0;
        end
    end

    always_comb begin
        w_lines = '0;
        for (int c = 0; c < VIS_CH; c++) begin
            w_lines[2*c +: 2] = fqe_pkg::f_gray(n_quad_phase[c]);
        end
        o_result.quad_lines   = w_lines;
        o_result.frame_done   = w_done;
        o_result.frames_total = n_frame_counter;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rx_phase          <= fqe_pkg::RX_SYNC0;
            r_length_shift      <= '0;
            r_length_index      <= '0;
            r_payload_len       <= '0;
            r_payload_index     <= '0;
            r_record_num        <= '0;
            r_xor_sum           <= '0;
            r_type_ok           <= 1'b0;
            r_record_count      <= '0;
            r_record_byte_index <= '0;
            r_record_channel    <= '0;
            r_record_value      <= '0;
            r_pending_set       <= '0;
            r_frame_counter     <= '0;
            for (int c = 0; c < CHANNELS; c++) begin
                r_pending_target[c] <= '0;
                r_target_pos[c]     <= '0;
                r_current_pos[c]    <= '0;
                r_quad_phase[c]     <= '0;
            end
        end else begin
            r_rx_phase          <= n_rx_phase;
            r_length_shift      <= n_length_shift;
            r_length_index      <= n_length_index;
            r_payload_len       <= n_payload_len;
            r_payload_index     <= n_payload_index;
            r_record_num        <= n_record_num;
            r_xor_sum           <= n_xor_sum;
            r_type_ok           <= n_type_ok;
            r_record_count      <= n_record_count;
            r_record_byte_index <= n_record_byte_index;
            r_record_channel    <= n_record_channel;
            r_record_value      <= n_record_value;
            r_pending_set       <= n_pending_set;
            r_frame_counter     <= n_frame_counter;
            r_pending_target    <= n_pending_target;
            r_target_pos        <= n_target_pos;
            r_current_pos       <= n_current_pos;
            r_quad_phase        <= n_quad_phase;
        end
    end

    a_tick_no_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_fire && i_op.is_tick) |-> !w_done)
        else $error("A step tick reported a completed frame.");

    a_frame_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_fire && w_done) |=> (r_frame_counter == $past(r_frame_counter) + 32'd1))
        else $error("Frame counter did not advance on a completed frame.");

    a_idle_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_fire |=> ($stable(r_rx_phase) && $stable(r_frame_counter)
                     && $stable(r_pending_set)))
        else $error("Engine state changed without a transaction.");

endmodule

// File: hdl/framed_quadrature_encoder_emulator.sv
// ----------------------------------------------------------------------------
// Framed quadrature encoder emulator
// Receives framed position targets and generates quadrature A/B levels.
//
//   Channel  | Handshake                 | Payload
//   ---------+---------------------------+------------------------------
//   input    | push / full               | i_item (kind, data_byte)
//   result   | empty / pop               | o_result (lines, done, total)
//   config   | i_cfg_valid / o_cfg_ready | i_cfg_index, i_cfg_data
//
// One transaction per cycle sustained while the result side keeps popping; every input yields one result.
// An accepted input waits in the input queue until the engine retires it and
// writes its result to the result queue, from which it can then be popped.
// The engine retires a whole byte or tick each time it takes one from the queue.
// Synchronous active-low reset; no clearing pass is needed.
// Either side may stall on its own; the two queues absorb the difference.
// ----------------------------------------------------------------------------
module framed_quadrature_encoder_emulator #(
    parameter int CHANNELS    = fqe_pkg::CHANNELS_DEF,
    parameter int MAX_PAYLOAD = fqe_pkg::MAX_PAYLOAD_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             push,
    output logic                             full,
    input  fqe_pkg::t_in_item                i_item,
    output logic                             empty,
    input  logic                             pop,
    output fqe_pkg::t_out_item               o_result,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [fqe_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [7:0]                       i_cfg_data
);

    localparam int OP_W  = $bits(fqe_pkg::t_op);
    localparam int RES_W = $bits(fqe_pkg::t_out_item);

    fqe_pkg::t_cfg_wr   w_cfg;
    fqe_pkg::t_op       w_front_op;
    fqe_pkg::t_op       w_back_op;
    fqe_pkg::t_out_item w_result;
    logic [OP_W-1:0]    w_op_bits;
    logic [RES_W-1:0]   w_res_bits;
    logic               w_op_empty;
    logic               w_op_pop;
    logic               w_res_full;
    logic               w_res_push;

    assign w_cfg.index = i_cfg_index;
    assign w_cfg.data  = i_cfg_data;
    assign w_back_op   = fqe_pkg::t_op'(w_op_bits);
    assign o_result    = fqe_pkg::t_out_item'(w_res_bits);

    fqe_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg       (w_cfg),
        .i_item      (i_item),
        .o_op        (w_front_op)
    );

    fqe_fifo #(
        .WIDTH (OP_W),
        .DEPTH (fqe_pkg::QUEUE_DEPTH)
    ) u_op_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (OP_W'(w_front_op)),
        .o_full  (full),
        .i_pop   (w_op_pop),
        .o_data  (w_op_bits),
        .o_empty (w_op_empty)
    );

    fqe_back #(
        .CHANNELS    (CHANNELS),
        .MAX_PAYLOAD (MAX_PAYLOAD)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_op       (w_back_op),
        .i_op_valid (!w_op_empty),
        .o_op_pop   (w_op_pop),
        .i_res_full (w_res_full),
        .o_res_push (w_res_push),
        .o_result   (w_result)
    );

    fqe_fifo #(
        .WIDTH (RES_W),
        .DEPTH (fqe_pkg::QUEUE_DEPTH)
    ) u_res_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_res_push),
        .i_data  (RES_W'(w_result)),
        .o_full  (w_res_full),
        .i_pop   (pop),
        .o_data  (w_res_bits),
        .o_empty (empty)
    );

endmodule
